// ===== rtl/hierarchical_bitset_intersect_top_defines.svh =====
// Assertion macros used by the checker module of the block.
`ifndef HIERARCHICAL_BITSET_INTERSECT_TOP_DEFINES_SVH
`define HIERARCHICAL_BITSET_INTERSECT_TOP_DEFINES_SVH

// Same-cycle implication, clocked by aclk and disabled while aresetn is low.
`define HBI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked by aclk and disabled while aresetn is low.
`define HBI_ASSERT_NIMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/hbi_pkg.sv =====
package hbi_pkg;

    localparam int DATA_W = 64;
    localparam int IDX_W = 6;
    localparam int CNT_W = 13;
    localparam int BYTE_W = 3;
    localparam int CHUNKS = DATA_W / 8;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 152;

    localparam logic [1:0] FUNC_WR_A = 2'd0;
    localparam logic [1:0] FUNC_WR_B = 2'd1;
    localparam logic [1:0] FUNC_RUN  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_LOAD,
        ST_COUNT,
        ST_EMIT
    } state_t;

    function automatic logic [3:0] popcount8(input logic [7:0] b);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'b000, b[i]};
        end
        return n;
    endfunction

endpackage

// ===== rtl/hierarchical_bitset_intersect_top.sv =====
// A load word is accepted only in idle and gives no result.
// A run scans the active leaves in index order; each surviving leaf is read, its
// intersection word counted a byte at a time, and emitted, waiting on m_tready;
// an empty run gives a single word with no active leaf and m_tlast set.
// The byte-serial popcount adder sets the per-leaf time.
// Reset clears both top masks and the per-entry valid bits of both leaf stores.
module hierarchical_bitset_intersect_top
    import hbi_pkg::*;
#(
    parameter int LEAF_WORDS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // word_index, word_value, zero padding
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func, is_top
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // top_mask, leaf_index, leaf_word, bit_count, zero padding
    output logic [M_TDATA_W-1:0] m_tdata,
    // leaf_valid
    output logic [0:0]           m_tuser,
    output logic                 m_tlast
);

    localparam int AW = (LEAF_WORDS > 1) ? $clog2(LEAF_WORDS) : 1;
    localparam logic [DATA_W-1:0] SPAN = (LEAF_WORDS >= DATA_W) ? '1 :
        ((DATA_W'(1) << LEAF_WORDS) - DATA_W'(1));

    logic [1:0]        in_func;
    logic              in_is_top;
    logic [IDX_W-1:0]  in_index;
    logic [DATA_W-1:0] in_value;
    logic              accept;
    logic              index_ok;
    logic              wr_a;
    logic              wr_b;
    logic              rd_en;
    logic [DATA_W-1:0] a_q;
    logic [DATA_W-1:0] b_q;
    logic [DATA_W-1:0] both_top;
    logic [LEAF_WORDS-1:0] one_hot;
    logic [LEAF_WORDS-1:0] rest;
    logic              out_free;

    state_t            state_reg, state_next;
    logic [DATA_W-1:0] a_top_reg, b_top_reg;
    logic [LEAF_WORDS-1:0] a_vld_reg, b_vld_reg;
    logic              a_hit_reg, b_hit_reg;
    logic [DATA_W-1:0] mask_reg, mask_next;
    logic [LEAF_WORDS-1:0] active_reg, active_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [DATA_W-1:0] word_reg, word_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              empty_reg, empty_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] out_mask_reg, out_mask_next;
    logic              out_lv_reg, out_lv_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic [DATA_W-1:0] out_word_reg, out_word_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic              out_last_reg, out_last_next;

    assign in_func   = s_tuser[1:0];
    assign in_is_top = s_tuser[2];
    assign in_index  = s_tdata[IDX_W-1:0];
    assign in_value  = s_tdata[IDX_W +: DATA_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign index_ok = ({1'b0, in_index} < (IDX_W + 1)'(LEAF_WORDS));
    assign wr_a     = accept && (in_func == FUNC_WR_A) && !in_is_top && index_ok;
    assign wr_b     = accept && (in_func == FUNC_WR_B) && !in_is_top && index_ok;
    assign rd_en    = (state_reg == ST_SCAN) && active_reg[idx_reg];
    assign both_top = a_top_reg & b_top_reg;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        one_hot = '0;
        one_hot[idx_reg] = 1'b1;
    end
    assign rest = active_reg & ~one_hot;

    hbi_ram #(
        .WIDTH  (DATA_W),
        .DEPTH  (LEAF_WORDS),
        .ADDR_W (AW)
    ) u_ram_a (
        .aclk    (aclk),
        .wr_en   (wr_a),
        .wr_addr (in_index[AW-1:0]),
        .wr_data (in_value),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (a_q)
    );

    hbi_ram #(
        .WIDTH  (DATA_W),
        .DEPTH  (LEAF_WORDS),
        .ADDR_W (AW)
    ) u_ram_b (
        .aclk    (aclk),
        .wr_en   (wr_b),
        .wr_addr (in_index[AW-1:0]),
        .wr_data (in_value),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (b_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            a_top_reg   <= '0;
            b_top_reg   <= '0;
            a_vld_reg   <= '0;
            b_vld_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (accept && in_is_top && (in_func == FUNC_WR_A)) begin
                a_top_reg <= in_value;
            end
            if (accept && in_is_top && (in_func == FUNC_WR_B)) begin
                b_top_reg <= in_value;
            end
            if (wr_a) begin
                a_vld_reg[in_index[AW-1:0]] <= 1'b1;
            end
            if (wr_b) begin
                b_vld_reg[in_index[AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            a_hit_reg <= a_vld_reg[idx_reg];
            b_hit_reg <= b_vld_reg[idx_reg];
        end
        mask_reg     <= mask_next;
        active_reg   <= active_next;
        idx_reg      <= idx_next;
        word_reg     <= word_next;
        cnt_reg      <= cnt_next;
        byte_reg     <= byte_next;
        empty_reg    <= empty_next;
        out_mask_reg <= out_mask_next;
        out_lv_reg   <= out_lv_next;
        out_idx_reg  <= out_idx_next;
        out_word_reg <= out_word_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
    end

    always_comb begin
        state_next    = state_reg;
        mask_next     = mask_reg;
        active_next   = active_reg;
        idx_next      = idx_reg;
        word_next     = word_reg;
        cnt_next      = cnt_reg;
        byte_next     = byte_reg;
        empty_next    = empty_reg;
        m_valid_next  = m_valid_reg;
        out_mask_next = out_mask_reg;
        out_lv_next   = out_lv_reg;
        out_idx_next  = out_idx_reg;
        out_word_next = out_word_reg;
        out_cnt_next  = out_cnt_reg;
        out_last_next = out_last_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (in_func == FUNC_RUN)) begin
                    mask_next   = both_top & SPAN;
                    active_next = both_top[LEAF_WORDS-1:0];
                    idx_next    = '0;
                    cnt_next    = '0;
                    state_next  = ST_START;
                end
            end
            ST_START: begin
                if (active_reg == '0) begin
                    empty_next = 1'b1;
                    word_next  = '0;
                    state_next = ST_EMIT;
                end else begin
                    empty_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (active_reg[idx_reg]) begin
                    state_next = ST_LOAD;
                end else begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_LOAD: begin
                word_next  = (a_hit_reg ? a_q : '0) & (b_hit_reg ? b_q : '0);
                byte_next  = '0;
                state_next = ST_COUNT;
            end
            ST_COUNT: begin
                cnt_next  = cnt_reg + CNT_W'(popcount8(word_reg[8*byte_reg +: 8]));
                byte_next = byte_reg + BYTE_W'(1);
                if (byte_reg == BYTE_W'(CHUNKS - 1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_mask_next = mask_reg;
                    out_lv_next   = !empty_reg;
                    out_idx_next  = empty_reg ? '0 : IDX_W'(idx_reg);
                    out_word_next = word_reg;
                    out_cnt_next  = cnt_reg;
                    out_last_next = empty_reg || (rest == '0);
                    active_next   = rest;
                    if (empty_reg || (rest == '0)) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - CNT_W - 2 * DATA_W - IDX_W)'(0), out_cnt_reg,
                       out_word_reg, out_idx_reg, out_mask_reg};
    assign m_tuser  = out_lv_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/hbi_ram.sv =====
module hbi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/hbi_checker.sv =====
`include "hierarchical_bitset_intersect_top_defines.svh"

module hbi_checker
    import hbi_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [0:0]           m_tuser,
    input logic                 m_tlast
);

    // A word without an active leaf only ends an empty run.
    `HBI_ASSERT_IMP(a_empty_last, m_tvalid && !m_tuser[0], m_tlast)
    `HBI_ASSERT_IMP(a_empty_zero, m_tvalid && !m_tuser[0], m_tdata == '0)
    `HBI_ASSERT_NIMP(a_run_busy, s_tvalid && s_tready && (s_tuser[1:0] == FUNC_RUN), !s_tready)
    `HBI_ASSERT_NIMP(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind hierarchical_bitset_intersect_top hbi_checker u_hbi_checker (.*);
